### hw/rtl/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Default geometry of the maps.
  localparam int unsigned MAP_BLOCKS_DEF = 65536;
  localparam int unsigned WORD_BITS_DEF  = 8;

  // Block numbers are 16 bits wide, so no more blocks than this can be addressed.
  localparam int unsigned BLOCK_BITS  = 16;
  localparam int unsigned BLOCK_SPACE = 65536;

  // Scan limit register.
  localparam int unsigned           LIM_W           = 17;
  localparam logic [LIM_W-1:0]      MAP_LIMIT_RESET = 17'h10000;

  // Allocation counter.
  localparam logic [BLOCK_BITS-1:0] COUNT_MAX = 16'hFFFF;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_TEST  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_ALLOC = 2'd3
  } kind_e;

  // Map select codes.
  localparam logic MAP_USED = 1'b0;
  localparam logic MAP_FREE = 1'b1;

  // One request item.
  typedef struct packed {
    logic [1:0]            kind;
    logic                  map_select;
    logic [BLOCK_BITS-1:0] block_number;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                  bit_value;
    logic [BLOCK_BITS-1:0] allocated_block;
    logic [BLOCK_BITS-1:0] allocated_count;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR    = 3'd0,
    ST_IDLE     = 3'd1,
    ST_DIV      = 3'd2,
    ST_RD       = 3'd3,
    ST_MOD      = 3'd4,
    ST_SCAN_RD  = 3'd5,
    ST_SCAN_CHK = 3'd6
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_wr;
    logic div_en;
    logic rd_bit;
    logic commit_bit;
    logic scan_init;
    logic scan_rd;
    logic scan_adv;
    logic commit_alloc;
    logic commit_none;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic past_limit;
    logic found;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds one bit map of the allocator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 8192,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/bba_ctrl.sv
// Controller state machine of the block bitmap allocator.
// Sequences the clearing pass, bit read-modify-writes and allocate scans; uses bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t      cmd_o
);

  import bba_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.is_alloc) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN_RD;
        end else begin
          cmd_o.div_en = 1'b1;
          state_d      = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_bit = 1'b1;
        state_d      = ST_MOD;
      end
      ST_MOD: begin
        // The write and the result go out together once the output register is free.
        if (sts_i.out_free) begin
          cmd_o.commit_bit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.past_limit) begin
          if (sts_i.out_free) begin
            cmd_o.commit_none = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.found) begin
          if (sts_i.out_free) begin
            cmd_o.commit_alloc = 1'b1;
            state_d            = ST_IDLE;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An accepted item always starts decoding in the next cycle.
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DIV))
    else $error("accepted item did not enter decode");

  // At most one result is produced per cycle.
  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.commit_bit, cmd_o.commit_alloc, cmd_o.commit_none}))
    else $error("more than one result committed in a cycle");

  // A result is only committed when the output register can take it.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit_bit || cmd_o.commit_alloc || cmd_o.commit_none) |-> sts_i.out_free)
    else $error("result committed over an unread result");

endmodule

`default_nettype wire

### hw/rtl/bba_dp.sv
// Datapath of the block bitmap allocator: request and limit registers, word/bit
// decode, the two map RAMs, scan logic, counter and result register. Uses bba_pkg, bba_ram.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp #(
  parameter int unsigned MAP_BLOCKS = bba_pkg::MAP_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bba_pkg::in_item_t          in_item_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic [bba_pkg::LIM_W-1:0]  cfg_data_i,
  input  wire logic                       out_stall_i,
  output logic                            out_valid_o,
  output bba_pkg::out_item_t              out_item_o,
  input  wire bba_pkg::cmd_t              cmd_i,
  output bba_pkg::sts_t                   sts_o
);

  import bba_pkg::*;

  // Only blocks that a 16-bit number can reach need storage.
  localparam int unsigned EFF_BLOCKS = (MAP_BLOCKS < BLOCK_SPACE) ? MAP_BLOCKS : BLOCK_SPACE;
  localparam int unsigned EFF_WORDS  = (EFF_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW         = (EFF_WORDS > 1) ? $clog2(EFF_WORDS) : 1;
  localparam int unsigned BW         = $clog2(WORD_BITS);

  // Block number / WORD_BITS as a multiply by a rounded-up reciprocal.
  localparam int unsigned       SHIFT   = BLOCK_BITS + BW;
  localparam int unsigned       RW      = SHIFT + 1;
  localparam int unsigned       PW      = BLOCK_BITS + RW;
  localparam longint unsigned   RECIP   = ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [RW-1:0]     RECIP_C = RW'(RECIP);

  localparam logic [LIM_W-1:0]  EFF_BLOCKS_C = LIM_W'(EFF_BLOCKS);
  localparam logic [LIM_W-1:0]  WORD_BITS_C  = LIM_W'(WORD_BITS);
  localparam logic [AW-1:0]     LAST_WORD    = AW'(EFF_WORDS - 1);

  in_item_t              item_q;
  logic [LIM_W-1:0]      map_limit_q;
  logic [BLOCK_BITS-1:0] quot_q, quot_d;
  logic [BW-1:0]         rem_q, rem_d;
  logic [AW-1:0]         clr_addr_q;
  logic [AW-1:0]         scan_word_q;
  logic [LIM_W-1:0]      scan_base_q;
  logic [BLOCK_BITS-1:0] cnt_q, cnt_d;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  logic [PW-1:0]         prod;
  logic [BLOCK_BITS-1:0] wmul;
  logic [BLOCK_BITS-1:0] rem_full;

  logic                  in_range;
  logic                  is_test;
  logic                  sel;
  logic [AW-1:0]         bit_addr;
  logic [WORD_BITS-1:0]  used_rdata, free_rdata;
  logic [WORD_BITS-1:0]  sel_word, bit_mask, bit_word;
  logic                  bit_write;

  logic [LIM_W-1:0]      lim;
  logic [LIM_W-1:0]      avail;
  logic                  found;
  logic [BW-1:0]         found_idx;
  logic [WORD_BITS-1:0]  alloc_mask;
  logic [LIM_W-1:0]      got_full;

  logic                  used_we, free_we, used_re, free_re;
  logic [AW-1:0]         used_waddr, free_waddr, used_raddr;
  logic [WORD_BITS-1:0]  used_wdata, free_wdata;

  // Scan limit register, written whenever the configuration channel offers data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_limit_q <= MAP_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      map_limit_q <= cfg_data_i;
    end
  end

  // Word and bit position of the requested block: quotient by reciprocal, then remainder.
  always_comb begin
    prod     = PW'(item_q.block_number) * RECIP_C;
    quot_d   = prod[SHIFT +: BLOCK_BITS];
    wmul     = quot_q * BLOCK_BITS'(WORD_BITS);
    rem_full = item_q.block_number - wmul;
    rem_d    = rem_full[BW-1:0];
  end

  // Request, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.div_en) begin
      quot_q <= quot_d;
    end
    if (cmd_i.rd_bit) begin
      rem_q <= rem_d;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Set, test and clear on one map word.
  always_comb begin
    in_range  = 32'(item_q.block_number) < MAP_BLOCKS;
    is_test   = item_q.kind == KIND_TEST;
    sel       = item_q.map_select;
    bit_addr  = quot_q[AW-1:0];
    sel_word  = (sel == MAP_FREE) ? free_rdata : used_rdata;
    bit_mask  = WORD_BITS'(1) << rem_q;
    bit_word  = (item_q.kind == KIND_CLEAR) ? (sel_word & ~bit_mask) : (sel_word | bit_mask);
    bit_write = cmd_i.commit_bit && in_range && !is_test;
  end

  // Scan of the used map: first clear bit below the limit in the current word.
  always_comb begin
    lim       = (map_limit_q > EFF_BLOCKS_C) ? EFF_BLOCKS_C : map_limit_q;
    avail     = lim - scan_base_q;
    found     = 1'b0;
    found_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!used_rdata[j] && (LIM_W'(j) < avail)) begin
        found     = 1'b1;
        found_idx = BW'(j);
      end
    end
    alloc_mask = WORD_BITS'(1) << found_idx;
    got_full   = scan_base_q + LIM_W'(found_idx);
  end

  // Scan position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      scan_word_q <= '0;
      scan_base_q <= '0;
    end else if (cmd_i.scan_adv) begin
      scan_word_q <= scan_word_q + AW'(1);
      scan_base_q <= scan_base_q + WORD_BITS_C;
    end
  end

  // Allocation counter, saturating.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.commit_alloc && (cnt_q != COUNT_MAX)) begin
      cnt_d = cnt_q + BLOCK_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // RAM port steering: clearing pass, bit update or allocation.
  always_comb begin
    used_re    = (cmd_i.rd_bit && (sel == MAP_USED)) || cmd_i.scan_rd;
    used_raddr = cmd_i.scan_rd ? scan_word_q : bit_addr;
    free_re    = cmd_i.rd_bit && (sel == MAP_FREE);

    used_we    = cmd_i.clr_wr || cmd_i.commit_alloc || (bit_write && (sel == MAP_USED));
    used_waddr = bit_addr;
    used_wdata = bit_word;
    if (cmd_i.clr_wr) begin
      used_waddr = clr_addr_q;
      used_wdata = '0;
    end else if (cmd_i.commit_alloc) begin
      used_waddr = scan_word_q;
      used_wdata = used_rdata | alloc_mask;
    end

    free_we    = cmd_i.clr_wr || (bit_write && (sel == MAP_FREE));
    free_waddr = cmd_i.clr_wr ? clr_addr_q : bit_addr;
    free_wdata = cmd_i.clr_wr ? '0 : bit_word;
  end

  bba_ram #(
    .Width (WORD_BITS),
    .Depth (EFF_WORDS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .re_i    (used_re),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  bba_ram #(
    .Width (WORD_BITS),
    .Depth (EFF_WORDS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .re_i    (free_re),
    .raddr_i (bit_addr),
    .rdata_o (free_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_bit || cmd_i.commit_alloc || cmd_i.commit_none) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_bit) begin
      out_item_q.bit_value       <= is_test ? (in_range & sel_word[rem_q]) : 1'b1;
      out_item_q.allocated_block <= '0;
      out_item_q.allocated_count <= cnt_q;
    end else if (cmd_i.commit_alloc) begin
      out_item_q.bit_value       <= 1'b1;
      out_item_q.allocated_block <= got_full[BLOCK_BITS-1:0];
      out_item_q.allocated_count <= cnt_d;
    end else if (cmd_i.commit_none) begin
      out_item_q.bit_value       <= 1'b1;
      out_item_q.allocated_block <= '0;
      out_item_q.allocated_count <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Status to the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = clr_addr_q == LAST_WORD;
    sts_o.is_alloc   = item_q.kind == KIND_ALLOC;
    sts_o.past_limit = scan_base_q >= lim;
    sts_o.found      = found;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Once full, the counter stays full.
  a_cnt_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == COUNT_MAX) |=> (cnt_q == COUNT_MAX))
    else $error("allocation counter wrapped");

  // An allocated block always lies below the scan limit.
  a_alloc_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_alloc |-> (got_full < lim))
    else $error("allocated block at or beyond the scan limit");

  // Scan reads never start at or past the limit.
  a_scan_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (scan_base_q < lim))
    else $error("scan read issued past the limit");

endmodule

`default_nettype wire

### hw/rtl/block_bitmap_allocator.sv
// Block bitmap allocator: set/test/clear give a valid result after decode, a map RAM read and
// the read-modify-write, and a new item is taken only once that result is written. Allocate
// scans the used map from word 0 until it finds a free block or reaches the scan limit
// (one RAM read and one check per word). The next item is taken in the cycle after the result
// is written; a stalled result in the output register holds back only the next item's result.
// After reset both maps are cleared one word per cycle (8192 words with the default geometry)
// with in_stall_o high; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator #(
  parameter int unsigned MAP_BLOCKS = bba_pkg::MAP_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire bba_pkg::in_item_t         in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bba_pkg::out_item_t             out_item_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [bba_pkg::LIM_W-1:0] cfg_data_i
);

  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The limit register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAP_BLOCKS (MAP_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### test/tb_block_bitmap_allocator.sv
// Self-checking testbench for block_bitmap_allocator: a directed table and random phases
// under several scan limits and idling patterns, checked against the table or a predictor.
// Depends on bba_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_block_bitmap_allocator;
  import bba_pkg::*;

  localparam int DRAIN_GAP   = 16;
  localparam int HOLD_CYCLES = 400;

  // One row of the directed table: either a limit write or a request.
  typedef struct packed {
    logic            is_cfg;
    logic [LIM_W-1:0] cfg_val;
    in_item_t        req;
    logic            exact;
    out_item_t       want;
  } step_t;

  localparam out_item_t NO_RESULT = '{1'b0, 16'd0, 16'd0};

  localparam step_t DIR_STEPS [30] = '{
    // Fresh maps after reset.
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b1, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_FREE, 16'hFFFF}, 1'b1, '{1'b0, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_SET,   MAP_USED, 16'hFFFF}, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'hFFFF}, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_SET,   MAP_FREE, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_FREE, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd0}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b1, '{1'b0, 16'd0, 16'd0}},
    // Allocation ignores the map select; block zero reads like a miss.
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_FREE, 16'hFFFF}, 1'b1, '{1'b1, 16'd0, 16'd1}},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd1, 16'd2}},
    '{1'b0, 17'd0, '{KIND_CLEAR, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd2}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b1, '{1'b0, 16'd0, 16'd2}},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd3}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'h0001}, 1'b1, '{1'b1, 16'd0, 16'd3}},
    '{1'b0, 17'd0, '{KIND_CLEAR, MAP_FREE, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd3}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_FREE, 16'h0000}, 1'b1, '{1'b0, 16'd0, 16'd3}},
    '{1'b0, 17'd0, '{KIND_SET,   MAP_USED, 16'h0002}, 1'b1, '{1'b1, 16'd0, 16'd3}},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd3, 16'd4}},
    '{1'b0, 17'd0, '{KIND_CLEAR, MAP_FREE, 16'hFFFF}, 1'b1, '{1'b1, 16'd0, 16'd4}},
    // A zero limit finds nothing, a limit of four sees only taken blocks.
    '{1'b1, 17'd0, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd4}},
    '{1'b1, 17'd4, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd0, 16'd4}},
    // A limit beyond the map is clamped.
    '{1'b1, 17'h1FFFF, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_ALLOC, MAP_USED, 16'h0000}, 1'b1, '{1'b1, 16'd4, 16'd5}},
    '{1'b1, MAP_LIMIT_RESET, '{KIND_TEST,  MAP_USED, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_SET,   MAP_USED, 16'h5555}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'hAAAA}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_FREE, 16'h5555}, 1'b0, NO_RESULT},
    '{1'b0, 17'd0, '{KIND_CLEAR, MAP_USED, 16'hFFFF}, 1'b1, '{1'b1, 16'd0, 16'd5}},
    '{1'b0, 17'd0, '{KIND_TEST,  MAP_USED, 16'hFFFF}, 1'b1, '{1'b0, 16'd0, 16'd5}}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LIM_W-1:0] cfg_data_i  = '0;

  // Shadow state of the block.
  bit               used_bits [BLOCK_SPACE];
  bit               free_bits [BLOCK_SPACE];
  logic [15:0]      alloc_cnt  = '0;
  logic [LIM_W-1:0] scan_limit = MAP_LIMIT_RESET;

  out_item_t        pending_results [$];
  logic             row_exact  = 1'b0;
  out_item_t        row_result = '0;
  int               n_sent     = 0;
  int               n_done     = 0;
  int               errors     = 0;
  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  int               hold_reqs  = 0;

  block_bitmap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one request to the shadow maps and return the result it should produce.
  function automatic out_item_t predict_request(in_item_t req);
    out_item_t res;
    int        lim;
    int        i;
    res.bit_value       = 1'b1;
    res.allocated_block = '0;
    case (req.kind)
      KIND_SET: begin
        if (req.map_select == MAP_FREE) free_bits[req.block_number] = 1'b1;
        else used_bits[req.block_number] = 1'b1;
      end
      KIND_TEST: begin
        res.bit_value = (req.map_select == MAP_FREE) ? free_bits[req.block_number]
                                                      : used_bits[req.block_number];
      end
      KIND_CLEAR: begin
        if (req.map_select == MAP_FREE) free_bits[req.block_number] = 1'b0;
        else used_bits[req.block_number] = 1'b0;
      end
      default: begin
        // First fit over the used map, the scan clamped to the block space.
        lim = (scan_limit > BLOCK_SPACE) ? BLOCK_SPACE : int'(scan_limit);
        for (i = 0; i < lim; i++) begin
          if (!used_bits[i]) begin
            used_bits[i] = 1'b1;
            if (alloc_cnt != COUNT_MAX) alloc_cnt = alloc_cnt + 16'd1;
            res.allocated_block = 16'(i);
            break;
          end
        end
      end
    endcase
    res.allocated_count = alloc_cnt;
    return res;
  endfunction

  function automatic in_item_t make_request(kind_e kind, logic sel, logic [15:0] blk);
    in_item_t req;
    req.kind         = kind;
    req.map_select   = sel;
    req.block_number = blk;
    return req;
  endfunction

  // Mostly low blocks, where allocations land, with some top-end and full-range noise.
  function automatic in_item_t rand_request();
    int          r;
    int          b;
    kind_e       kind;
    logic [15:0] blk;
    r = $urandom_range(99);
    if (r < 30) kind = KIND_ALLOC;
    else if (r < 55) kind = KIND_SET;
    else if (r < 80) kind = KIND_TEST;
    else kind = KIND_CLEAR;
    b = $urandom_range(99);
    if (b < 55) blk = 16'($urandom_range(63));
    else if (b < 65) blk = 16'($urandom_range(65535, 65472));
    else blk = 16'($urandom_range(65535));
    return make_request(kind, 1'($urandom_range(1)), blk);
  endfunction

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_req(in_item_t req, logic exact, out_item_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    row_exact  <= exact;
    row_result <= want;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  // Stop offering and wait until every sent item has produced its result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (n_done < n_sent) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [LIM_W-1:0] lim, int snd_pct, int rcv_pct, int count,
                           bit long_hold, bit mid_pause);
    wait_drained();
    write_limit(lim);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        if (long_hold) hold_reqs++;
        if (mid_pause) wait_drained();
      end
      send_req(rand_request(), 1'b0, NO_RESULT);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin : receiver
    int hold_seen;
    int hold_left;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Check results, predict accepted items and track limit writes.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_item_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.bit_value !== want.bit_value) begin
            $display("%0t: bit_value expected %0d, got %0d", $time,
                     want.bit_value, out_item_o.bit_value);
            errors++;
          end
          if (out_item_o.allocated_block !== want.allocated_block) begin
            $display("%0t: allocated_block expected %0d, got %0d", $time,
                     want.allocated_block, out_item_o.allocated_block);
            errors++;
          end
          if (out_item_o.allocated_count !== want.allocated_count) begin
            $display("%0t: allocated_count expected %0d, got %0d", $time,
                     want.allocated_count, out_item_o.allocated_count);
            errors++;
          end
        end
        n_done++;
      end
      if (in_valid_i && !in_stall_o) begin
        pred = predict_request(in_item_i);
        pending_results.push_back(row_exact ? row_result : pred);
      end
      if (cfg_valid_i && cfg_ready_o) scan_limit = cfg_data_i;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    snd_idle_pct = 22;
    rcv_idle_pct = 73;
    foreach (DIR_STEPS[r]) begin
      if (DIR_STEPS[r].is_cfg) begin
        wait_drained();
        write_limit(DIR_STEPS[r].cfg_val);
      end else begin
        send_req(DIR_STEPS[r].req, DIR_STEPS[r].exact, DIR_STEPS[r].want);
      end
    end

    // Random phases under several limits and idling patterns.
    run_phase(17'd16,          22, 73, 200, 1'b0, 1'b0);
    run_phase(17'h1FFFF,       22, 73, 150, 1'b1, 1'b0);
    run_phase(17'd1000,        73, 22, 200, 1'b0, 1'b0);
    run_phase(17'd0,           73, 22, 100, 1'b0, 1'b1);
    run_phase(MAP_LIMIT_RESET,  0,  0, 200, 1'b1, 1'b1);
    run_phase(17'd40,           0,  0, 150, 1'b0, 1'b0);

    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
